### rtl/core/counting_key_table_assert.svh
// Assertion macros for the counting key table.
`ifndef COUNTING_KEY_TABLE_ASSERT_SVH
`define COUNTING_KEY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Checks an implication on every clock edge outside reset.
`define CKT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("counting_key_table check failed");
// Checks that a condition never holds on a clock edge outside reset.
`define CKT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("counting_key_table forbidden condition seen");
`else
`define CKT_ASSERT(label, prop)
`define CKT_NEVER(label, cond)
`endif
`endif

### rtl/core/ckt_pkg.sv
package ckt_pkg;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INC    = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_DROP   = 3'd3;
    localparam logic [2:0] OP_DONE   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_LIMIT  = 2'd3;

    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;
    localparam logic [15:0] SAMP_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] count;
        logic [15:0] samplers;
        logic        processing;
        logic        removed;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [30:0] count;
        logic        processing;
        logic [15:0] samplers;
    } entry_t;

endpackage

### rtl/core/ckt_mem.sv
module ckt_mem
    import ckt_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // Single write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/counting_key_table.sv
// Counting key table: each request word runs a linear scan of the entry
// memory, one entry per cycle, and then one read-modify-write step; the
// single read port of the entry memory sets that scan rate. After reset
// the block clears the memory and holds req_stall high meanwhile.
// A response waits in an output register, so the next word may be accepted
// before the previous response has been taken.
module counting_key_table
    import ckt_pkg::*;
#(
    parameter int ENTRIES = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

`include "counting_key_table_assert.svh"

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW:0] LAST = ENTRIES[AW:0];

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;

    logic [2:0]    state_reg, state_next;
    logic [AW:0]   ptr_reg, ptr_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    entry_t        hit_ent_reg, hit_ent_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    req_t          req_reg, req_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    entry_t        rd_data;
    logic          out_free;
    entry_t        ent;
    rsp_t          res;
    logic          res_write;
    logic          res_remove;

    ckt_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Operation on the found entry, worked out in the execute state.
    always_comb
    begin
        ent        = hit_ent_reg;
        res        = '0;
        res.status = ST_OK;
        res_write  = 1'b0;
        res_remove = 1'b0;
        if (req_reg.op == OP_INC)
        begin
            if (!hit_reg)
            begin
                if (!free_reg)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    ent.valid      = 1'b1;
                    ent.key        = req_reg.key;
                    ent.count      = 31'd1;
                    ent.processing = 1'b1;
                    ent.samplers   = 16'd0;
                    res_write      = 1'b1;
                end
            end
            else
            begin
                ent.processing = 1'b1;
                res_write      = 1'b1;
                if (ent.count == COUNT_MAX)
                begin
                    res.status = ST_LIMIT;
                end
                else
                begin
                    ent.count = ent.count + 31'd1;
                end
            end
        end
        else if (!hit_reg)
        begin
            res.status = ST_ABSENT;
        end
        else if (req_reg.op == OP_ADD)
        begin
            if (ent.samplers == SAMP_MAX)
            begin
                res.status = ST_LIMIT;
            end
            else
            begin
                ent.samplers = ent.samplers + 16'd1;
                res_write    = 1'b1;
            end
        end
        else if (req_reg.op == OP_DROP)
        begin
            if (ent.samplers == 16'd0)
            begin
                res.status = ST_LIMIT;
            end
            else
            begin
                ent.samplers = ent.samplers - 16'd1;
                res_write    = 1'b1;
                res_remove   = (ent.samplers == 16'd0) && !ent.processing;
            end
        end
        else if (req_reg.op == OP_DONE)
        begin
            ent.processing = 1'b0;
            res_write      = 1'b1;
            res_remove     = (ent.samplers == 16'd0);
        end
        if (res_remove)
        begin
            ent.valid   = 1'b0;
            res.removed = 1'b1;
        end
        else if (res.status == ST_OK || res.status == ST_LIMIT)
        begin
            res.count      = ent.count;
            res.samplers   = ent.samplers;
            res.processing = ent.processing;
        end
    end

    // Sequencer: clearing pass, idle accept, scan and execute.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cmp_vld_next   = 1'b0;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_ent_next   = hit_ent_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_data        = '0;
        rd_en          = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    ptr_next   = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (ptr_reg != LAST)
                begin
                    rd_en        = 1'b1;
                    ptr_next     = ptr_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                // Compare the entry read in the previous cycle.
                if (cmp_vld_reg)
                begin
                    if (rd_data.valid && rd_data.key == req_reg.key)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = hit_idx_reg;
                        hit_ent_next = rd_data;
                    end
                    if (!rd_data.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = ptr_reg[AW-1:0] - 1'b1;
                    end
                    if (rd_data.valid && rd_data.key == req_reg.key)
                    begin
                        hit_idx_next = ptr_reg[AW-1:0] - 1'b1;
                    end
                end
                if (ptr_reg == LAST && !cmp_vld_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    wr_en          = res_write;
                    wr_addr        = hit_reg ? hit_idx_reg : free_idx_reg;
                    wr_data        = ent;
                    rsp_valid_next = 1'b1;
                    rsp_next       = res;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        free_idx_reg <= free_idx_next;
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
    end

    // A freed entry reports empty fields.
    `CKT_ASSERT(a_removed_empty, rsp_valid && rsp_data.removed |-> rsp_data.count == 31'd0)
    // The execute cycle only follows a completed scan.
    `CKT_ASSERT(a_exec_after_scan, state_reg == S_EXEC |-> ptr_reg == LAST && !cmp_vld_reg)
    // An accepted word always starts a fresh scan.
    `CKT_ASSERT(a_accept_scan, req_valid && !req_stall |=> state_reg == S_SCAN && !hit_reg)
    // A refused insert never reports a count.
    `CKT_NEVER(a_full_empty, rsp_valid && rsp_data.status == ST_FULL && rsp_data.count != 31'd0)

endmodule
